// ===== rtl/mdio_mm_pkg.sv =====
// Package for the MDIO management master: frame layout constants and the
// payload types used by the sequencer, the result stage and the top level.
// Depends on nothing.
package mdio_mm_pkg;

  // Register reset value: beats per half period of the management clock.
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd16;

  // Half-period markers within a frame.
  localparam logic [7:0] SEND_HALVES_WRITE = 8'd128;
  localparam logic [7:0] SEND_HALVES_READ  = 8'd92;
  localparam logic [7:0] TOTAL_WRITE       = 8'd130;
  localparam logic [7:0] TOTAL_READ        = 8'd138;
  localparam logic [7:0] TA_END_READ       = 8'd102;
  localparam logic [7:0] RX_FIRST          = 8'd104;
  localparam logic [7:0] RX_LAST           = 8'd135;
  localparam logic [7:0] IDLE_HIGH_READ    = 8'd136;

  // Frame kind as carried in the request.
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Fixed frame fields.
  localparam logic [31:0] PREAMBLE     = 32'hFFFF_FFFF;
  localparam logic [1:0]  START_CODE   = 2'b01;
  localparam logic [1:0]  OP_CODE      = 2'b00;
  localparam logic [1:0]  WRITE_TA     = 2'b10;

  // Levels on the three pins.
  typedef struct packed {
    logic drive;
    logic data;
    logic mdc;
  } pins_t;

  // One request beat.
  typedef struct packed {
    logic        start_req;
    logic        kind;
    logic [4:0]  phy_addr;
    logic [4:0]  reg_num;
    logic [15:0] write_data;
    logic        mdio_in;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic        mdc;
    logic        mdio_out;
    logic        mdio_drive;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_data;
  } res_t;

  // Handshake control between the sequencer and the result stage.
  typedef struct packed {
    logic accept;
    logic ready;
  } step_ctrl_t;

endpackage

// ===== rtl/mdio_mm_req_if.sv =====
// Request channel interface for the MDIO management master.
// Carries valid, ready and the request fields. Depends on nothing.
interface mdio_mm_req_if;
  logic        valid;
  logic        ready;
  logic        start_req;
  logic        kind;
  logic [4:0]  phy_addr;
  logic [4:0]  reg_num;
  logic [15:0] write_data;
  logic        mdio_in;

  modport source (
    output valid, start_req, kind, phy_addr, reg_num, write_data, mdio_in,
    input  ready
  );
  modport sink (
    input  valid, start_req, kind, phy_addr, reg_num, write_data, mdio_in,
    output ready
  );
endinterface

// ===== rtl/mdio_mm_res_if.sv =====
// Result channel interface for the MDIO management master.
// Carries valid, ready and the pin and status fields. Depends on nothing.
interface mdio_mm_res_if;
  logic        valid;
  logic        ready;
  logic        mdc;
  logic        mdio_out;
  logic        mdio_drive;
  logic        busy_res;
  logic        done_res;
  logic [15:0] read_data;

  modport source (
    output valid, mdc, mdio_out, mdio_drive, busy_res, done_res, read_data,
    input  ready
  );
  modport sink (
    input  valid, mdc, mdio_out, mdio_drive, busy_res, done_res, read_data,
    output ready
  );
endinterface

// ===== rtl/mdio_management_master.sv =====
// MDIO management master. Each request beat is one clock step of the block: it
// may start a frame (start_req, only when no frame runs) and carries the
// sampled data pin, and it yields exactly one result beat with the management
// clock, data, data-enable, busy, done and the last read data. One beat can be
// taken every cycle and its result beat is offered in the next cycle; the frame
// sequencer steps once per accepted beat. A result beat that is not taken holds
// off the request channel, and the next request beat enters in the cycle in
// which it leaves.
// A frame lasts half_period beats per half period of mdc: 130 half periods for
// a write, 138 for a read. Reset sets half_period to 16; a value of zero
// counts as one.
// Depends on mdio_mm_pkg, mdio_mm_req_if, mdio_mm_res_if, mdio_mm_seq and
// mdio_mm_out.
module mdio_management_master (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  mdio_mm_req_if.sink   req,
  mdio_mm_res_if.source res
);
  import mdio_mm_pkg::*;

  req_t       req_beat;
  res_t       res_next;
  res_t       res_data;
  step_ctrl_t ctrl;

  // Gather the request fields.
  always_comb begin
    req_beat.start_req  = req.start_req;
    req_beat.kind       = req.kind;
    req_beat.phy_addr   = req.phy_addr;
    req_beat.reg_num    = req.reg_num;
    req_beat.write_data = req.write_data;
    req_beat.mdio_in    = req.mdio_in;
  end

  mdio_mm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctrl      (ctrl),
    .req       (req_beat),
    .res_next  (res_next)
  );

  mdio_mm_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .out_ready (res.ready),
    .res_next  (res_next),
    .ctrl      (ctrl),
    .out_valid (res.valid),
    .res_data  (res_data)
  );

  // Drive the result channel.
  assign req.ready      = ctrl.ready;
  assign res.mdc        = res_data.mdc;
  assign res.mdio_out   = res_data.mdio_out;
  assign res.mdio_drive = res_data.mdio_drive;
  assign res.busy_res   = res_data.busy_res;
  assign res.done_res   = res_data.done_res;
  assign res.read_data  = res_data.read_data;

endmodule

// ===== rtl/mdio_mm_seq.sv =====
// Frame sequencer: half-period divider, half index, send and receive shift
// registers, and the pin levels. Advances once per accepted request beat.
// Depends on mdio_mm_pkg.
module mdio_mm_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [15:0]              cfg_wdata,
  input  mdio_mm_pkg::step_ctrl_t  ctrl,
  input  mdio_mm_pkg::req_t        req,
  output mdio_mm_pkg::res_t        res_next
);
  import mdio_mm_pkg::*;

  logic [15:0] half_period;
  logic [15:0] divider_count;
  logic [7:0]  half_bit_index;
  logic [63:0] send_shift;
  logic [15:0] receive_shift;
  logic        frame_active;
  logic        frame_is_write;
  pins_t       pin_levels;

  logic [15:0] divider_count_next;
  logic [7:0]  half_bit_index_next;
  logic [63:0] send_shift_next;
  logic [15:0] receive_shift_next;
  logic        frame_active_next;
  logic        frame_is_write_next;
  pins_t       pin_levels_next;
  logic        done_next;

  logic        launch;
  logic        act;
  logic        is_wr;
  logic [63:0] shift_cur;
  logic [7:0]  h;
  logic [15:0] dc;
  logic [15:0] dc_inc;
  logic [15:0] hp_eff;
  logic        half_end;
  logic [7:0]  send_lim;
  logic [7:0]  total;
  logic [7:0]  h_inc;
  logic [63:0] frame_word;
  pins_t       pins_half;

  // Frame word for a new request; the write tail is only sent on writes.
  always_comb begin
    frame_word = {PREAMBLE, START_CODE, OP_CODE, req.phy_addr, req.reg_num,
                  18'd0};
    if (req.kind == KIND_WRITE) begin
      frame_word[17:0] = {WRITE_TA, req.write_data};
    end
  end

  // Current frame view: a new request takes effect in its own beat.
  always_comb begin
    launch    = !frame_active && req.start_req;
    act       = frame_active || launch;
    is_wr     = launch ? req.kind : frame_is_write;
    shift_cur = launch ? frame_word : send_shift;
    h         = launch ? 8'd0 : half_bit_index;
    dc        = launch ? 16'd0 : divider_count;
    send_lim  = is_wr ? SEND_HALVES_WRITE : SEND_HALVES_READ;
    total     = is_wr ? TOTAL_WRITE : TOTAL_READ;
    hp_eff    = (half_period == 16'd0) ? 16'd1 : half_period;
    dc_inc    = dc + 16'd1;
    half_end  = dc_inc >= hp_eff;
    h_inc     = h + 8'd1;
  end

  // Pin levels for the current half; data holds outside send halves.
  always_comb begin
    pins_half.data  = pin_levels.data;
    pins_half.drive = 1'b0;
    pins_half.mdc   = 1'b0;
    if (h < send_lim) begin
      pins_half.drive = 1'b1;
      pins_half.data  = shift_cur[63];
      pins_half.mdc   = h[0];
    end else if (is_wr) begin
      pins_half.drive = 1'b1;
      pins_half.mdc   = (h == SEND_HALVES_WRITE);
    end else if (h < TA_END_READ) begin
      pins_half.mdc   = 1'b0;
    end else if (h < RX_FIRST) begin
      pins_half.mdc   = (h == TA_END_READ);
    end else if (h <= RX_LAST) begin
      // Receive clocks start high on an even half.
      pins_half.mdc   = !h[0];
    end else begin
      pins_half.drive = 1'b1;
      pins_half.mdc   = (h == IDLE_HIGH_READ);
    end
  end

  // Next state for one beat.
  always_comb begin
    divider_count_next  = divider_count;
    half_bit_index_next = half_bit_index;
    send_shift_next     = shift_cur;
    receive_shift_next  = receive_shift;
    frame_active_next   = act;
    frame_is_write_next = is_wr;
    pin_levels_next     = pin_levels;
    done_next           = 1'b0;
    if (act) begin
      pin_levels_next     = pins_half;
      divider_count_next  = dc_inc;
      half_bit_index_next = h;
      if (half_end) begin
        // Shift out after the high half of each sent bit.
        if ((h < send_lim) && h[0]) begin
          send_shift_next = {shift_cur[62:0], 1'b0};
        end
        // Sample after each low half of the receive clocks.
        if (!is_wr && (h >= RX_FIRST) && (h <= RX_LAST) && h[0]) begin
          receive_shift_next = {receive_shift[14:0], req.mdio_in};
        end
        divider_count_next  = 16'd0;
        half_bit_index_next = h_inc;
        if (h_inc >= total) begin
          half_bit_index_next = 8'd0;
          frame_active_next   = 1'b0;
          done_next           = 1'b1;
        end
      end
    end
  end

  // Result fields follow the updated state.
  always_comb begin
    res_next.mdc        = pin_levels_next.mdc;
    res_next.mdio_out   = pin_levels_next.data;
    res_next.mdio_drive = pin_levels_next.drive;
    res_next.busy_res   = act;
    res_next.done_res   = done_next;
    res_next.read_data  = receive_shift_next;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RESET;
    end else if (cfg_we) begin
      half_period <= cfg_wdata;
    end
  end

  // Sequencer state advances on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      divider_count  <= 16'd0;
      half_bit_index <= 8'd0;
      send_shift     <= 64'd0;
      receive_shift  <= 16'd0;
      frame_active   <= 1'b0;
      frame_is_write <= 1'b0;
      pin_levels     <= '{drive: 1'b1, data: 1'b0, mdc: 1'b0};
    end else if (ctrl.accept) begin
      divider_count  <= divider_count_next;
      half_bit_index <= half_bit_index_next;
      send_shift     <= send_shift_next;
      receive_shift  <= receive_shift_next;
      frame_active   <= frame_active_next;
      frame_is_write <= frame_is_write_next;
      pin_levels     <= pin_levels_next;
    end
  end

endmodule

// ===== rtl/mdio_mm_out.sv =====
// Result stage: one output register with its valid flag, so a new request
// beat can enter in the cycle in which the previous result leaves.
// Depends on mdio_mm_pkg.
module mdio_mm_out (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     out_ready,
  input  mdio_mm_pkg::res_t        res_next,
  output mdio_mm_pkg::step_ctrl_t  ctrl,
  output logic                     out_valid,
  output mdio_mm_pkg::res_t        res_data
);
  import mdio_mm_pkg::*;

  logic res_valid;

  // Take a beat when the register is empty or is being emptied.
  always_comb begin
    ctrl.ready  = !res_valid || out_ready;
    ctrl.accept = in_valid && ctrl.ready;
  end

  assign out_valid = res_valid;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl.ready) begin
      res_valid <= in_valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      res_data <= res_next;
    end
  end

endmodule
